// ----- src/block_reverse_every_k_core_assert.svh -----
// Assertion macros for the block_reverse_every_k_core checker.
// No dependencies; included by the checker file.
`ifndef BLOCK_REVERSE_EVERY_K_CORE_ASSERT_SVH
`define BLOCK_REVERSE_EVERY_K_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BREK_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("brek assertion failed");

// next-cycle implication, disabled during reset
`define BREK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("brek assertion failed");

`endif

// ----- src/brek_pkg.sv -----
// Shared types and fixed widths for the group reversal block.
// No dependencies; used by the controller, datapath and top level.
package brek_pkg;

	localparam int GS_W  = 5;   // group size register width
	localparam int VAL_W = 32;  // word value width on the ports

	// controller -> datapath commands
	typedef struct packed {
		logic wr_en;    // store incoming word at wr_addr
		logic rd_en;    // read one held word at rd_addr
		logic rd_last;  // word being read ends the run
		logic rd_fin;   // run closes the stream
	} ctl_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic rd_ok;    // read stage can take a new read this cycle
	} dp_stat_t;

endpackage

// ----- src/brek_ctrl.sv -----
// Controller for the group reversal block: fill counter, group size register,
// emission sequencer. Depends on brek_pkg.
module brek_ctrl
	import brek_pkg::*;
#(
	parameter int MAX_GROUP = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         group_size_we,
	input  logic [GS_W-1:0]              group_size,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         final_item,
	input  dp_stat_t                     stat,
	output ctl_cmd_t                     cmd,
	output logic [$clog2(MAX_GROUP)-1:0] wr_addr,
	output logic [$clog2(MAX_GROUP)-1:0] rd_addr
);

	localparam int AW   = $clog2(MAX_GROUP);
	localparam int CW   = $clog2(MAX_GROUP + 1);
	localparam int CMPW = (CW > GS_W) ? CW : GS_W;

	typedef enum logic {ST_IDLE, ST_EMIT} state_t;

	state_t          state_q;
	logic [GS_W-1:0] gsize_q;
	logic [CW-1:0]   fill_q;
	logic [CW-1:0]   rem_q;
	logic [AW-1:0]   addr_q;
	logic            rev_q;
	logic            fin_q;

	logic          accept;
	logic [CW-1:0] n_held;
	logic          full_grp;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign n_held   = fill_q + CW'(1);
	// a size above MAX_GROUP acts as MAX_GROUP; held count never exceeds it
	assign full_grp = (CMPW'(n_held) >= CMPW'(gsize_q)) || (n_held == CW'(MAX_GROUP));

	assign cmd.wr_en   = accept;
	assign cmd.rd_en   = (state_q == ST_EMIT) && stat.rd_ok;
	assign cmd.rd_last = (rem_q == CW'(1));
	assign cmd.rd_fin  = fin_q;
	assign wr_addr     = fill_q[AW-1:0];
	assign rd_addr     = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gsize_q <= '0;
			fill_q  <= '0;
			rem_q   <= '0;
			addr_q  <= '0;
			rev_q   <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			if (group_size_we) begin
				gsize_q <= group_size;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (full_grp || final_item) begin
							state_q <= ST_EMIT;
							rem_q   <= n_held;
							rev_q   <= full_grp;
							fin_q   <= final_item;
							addr_q  <= full_grp ? fill_q[AW-1:0] : '0;
							fill_q  <= '0;
						end else begin
							fill_q <= n_held;
						end
					end
				end
				ST_EMIT: begin
					if (cmd.rd_en) begin
						addr_q <= rev_q ? (addr_q - AW'(1)) : (addr_q + AW'(1));
						rem_q  <= rem_q - CW'(1);
						if (rem_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/brek_dpath.sv -----
// Datapath for the group reversal block: word store, registered read stage,
// output register. Depends on brek_pkg.
module brek_dpath
	import brek_pkg::*;
#(
	parameter int MAX_GROUP  = 16,
	parameter int ITEM_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ctl_cmd_t                     cmd,
	input  logic [$clog2(MAX_GROUP)-1:0] wr_addr,
	input  logic [$clog2(MAX_GROUP)-1:0] rd_addr,
	output dp_stat_t                     stat,
	input  logic signed [VAL_W-1:0]      value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [VAL_W-1:0]      value_res,
	output logic                         run_end,
	output logic                         stream_end
);

	logic signed [ITEM_WIDTH-1:0] mem [MAX_GROUP];

	logic                         rd_valid_s1;
	logic signed [ITEM_WIDTH-1:0] rd_data_s1;
	logic                         rd_last_s1;
	logic                         rd_fin_s1;

	logic                         out_valid_q;
	logic signed [VAL_W-1:0]      value_q;
	logic                         run_end_q;
	logic                         stream_end_q;

	logic load_out;

	assign load_out   = rd_valid_s1 && (!out_valid_q || out_ready);
	// read data is held until moved on, so a new read only when it leaves
	assign stat.rd_ok = !rd_valid_s1 || load_out;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= ITEM_WIDTH'(value);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_last_s1 <= cmd.rd_last;
			rd_fin_s1  <= cmd.rd_fin && cmd.rd_last;
		end
		if (load_out) begin
			value_q      <= VAL_W'(rd_data_s1);
			run_end_q    <= rd_last_s1;
			stream_end_q <= rd_fin_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en || (rd_valid_s1 && !load_out);
			out_valid_q <= load_out || (out_valid_q && !out_ready);
		end
	end

	assign out_valid  = out_valid_q;
	assign value_res  = value_q;
	assign run_end    = run_end_q;
	assign stream_end = stream_end_q;

endmodule

// ----- src/block_reverse_every_k_core.sv -----
// Top level of the group reversal block: controller plus datapath.
// Depends on brek_pkg, brek_ctrl and brek_dpath.
//
// Usage:
//  - Input channel in_valid/in_ready carries one word (value, final_item).
//  - Output channel out_valid/out_ready carries one word (value_res, run_end, stream_end).
//  - group_size_we/group_size load the group size; write only while idle.
//    0 or 1 passes words straight through; above MAX_GROUP acts as MAX_GROUP.
//  - Words collect in the store. When the held count reaches the group size
//    the group leaves newest first; a short group closed by final_item leaves
//    in arrival order. run_end flags the last word of each run, stream_end the
//    last word of the stream.
// Timing:
//  - Accepting a word is one store write. A run of n words is then read
//    with one store read per cycle while the read stage can take it; each word
//    passes the registered read stage and then the output register.
//  - Store writes and reads never overlap: in_ready is low while a run is
//    being read out.
// Reset clears the fill count, the group size (to 0) and all valid flags.
// A receiver stall holds the output and pending read words; reading waits, nothing drops.
module block_reverse_every_k_core
	import brek_pkg::*;
#(
	parameter int MAX_GROUP  = 16,
	parameter int ITEM_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    group_size_we,
	input  logic [GS_W-1:0]         group_size,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    final_item,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] value_res,
	output logic                    run_end,
	output logic                    stream_end
);

	localparam int AW = $clog2(MAX_GROUP);

	ctl_cmd_t      cmd;
	dp_stat_t      stat;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	brek_ctrl #(
		.MAX_GROUP (MAX_GROUP)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.group_size_we (group_size_we),
		.group_size    (group_size),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.final_item    (final_item),
		.stat          (stat),
		.cmd           (cmd),
		.wr_addr       (wr_addr),
		.rd_addr       (rd_addr)
	);

	brek_dpath #(
		.MAX_GROUP  (MAX_GROUP),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.wr_addr    (wr_addr),
		.rd_addr    (rd_addr),
		.stat       (stat),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value_res  (value_res),
		.run_end    (run_end),
		.stream_end (stream_end)
	);

endmodule

// ----- src/brek_checker.sv -----
// Port-level checker for block_reverse_every_k_core, bound to the top level.
// Depends on block_reverse_every_k_core_assert.svh and brek_pkg.
`include "block_reverse_every_k_core_assert.svh"

module brek_checker
	import brek_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    final_item,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [VAL_W-1:0] value_res,
	input logic                    run_end,
	input logic                    stream_end
);

	// stalled output word holds
	`BREK_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(value_res))

	// end of stream always closes a run
	`BREK_ASSERT_NOW(a_end_in_run, clk, arst_n, out_valid && stream_end, run_end)

	// a final word always starts a readout, so input stalls next cycle
	`BREK_ASSERT_NXT(a_fin_emits, clk, arst_n, in_valid && in_ready && final_item, !in_ready)

endmodule

bind block_reverse_every_k_core brek_checker u_brek_checker (.*);

// ----- verif/block_reverse_every_k_core_tb.sv -----
// Testbench for block_reverse_every_k_core: random and directed word streams
// checked against an in-bench predictor of the group reversal.
// Depends on brek_pkg and block_reverse_every_k_core.
module block_reverse_every_k_core_tb
	import brek_pkg::*;
();

	localparam int MAX_GROUP    = 16;
	localparam int ITEM_WIDTH   = 32;
	localparam int RAND_WORDS   = 360;
	localparam int SETTLE_CYC   = 8;       // read pipeline depth plus margin
	localparam int CYCLE_LIMIT  = 200000;

	// one word on the output channel
	typedef struct {
		logic signed [VAL_W-1:0] val;
		logic                    run_last;
		logic                    strm_last;
	} out_word_t;

	logic                    clk;
	logic                    arst_n        = 1'b0;
	logic                    group_size_we = 1'b0;
	logic [GS_W-1:0]         group_size    = '0;
	logic                    in_valid      = 1'b0;
	logic                    in_ready;
	logic signed [VAL_W-1:0] value         = '0;
	logic                    final_item    = 1'b0;
	logic                    out_valid;
	logic                    out_ready     = 1'b0;
	logic signed [VAL_W-1:0] value_res;
	logic                    run_end;
	logic                    stream_end;

	// predictor state: its own copy of the store, fill count and group size
	logic signed [VAL_W-1:0] held_words [MAX_GROUP];
	int unsigned             held_cnt  = 0;
	logic [GS_W-1:0]         gsize_cur = '0;

	out_word_t pending_out[$];   // words the block still owes, oldest first
	int        err_cnt   = 0;
	int        sent_cnt  = 0;
	int        burst_left = 0;
	int        cycle_cnt = 0;

	block_reverse_every_k_core #(
		.MAX_GROUP (MAX_GROUP),
		.ITEM_WIDTH(ITEM_WIDTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.group_size_we(group_size_we),
		.group_size   (group_size),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.final_item   (final_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.value_res    (value_res),
		.run_end      (run_end),
		.stream_end   (stream_end)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run watchdog. Slowest run: ~400 words, each behind a receiver stall
	// plus sender gaps and drains, well under the limit.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("block_reverse_every_k_core_tb: FAIL");
			$finish;
		end
	end

	// Predict the words caused by one accepted input word.
	// Words collect until the held count reaches the group size; then the
	// whole store leaves newest first. A final word closing a short group
	// flushes it in arrival order. Size above MAX_GROUP clamps to MAX_GROUP;
	// 0 and 1 give n >= k at once, i.e. pass-through (or a reversed flush of
	// whatever was held before the size was lowered).
	task automatic reorder_predict(input logic signed [VAL_W-1:0] v, input logic fin);
		int unsigned k;
		int unsigned n;
		bit          rev;
		out_word_t   w;
		k = (gsize_cur > MAX_GROUP) ? MAX_GROUP : gsize_cur;
		if (held_cnt < MAX_GROUP) begin
			held_words[held_cnt] = v;
			held_cnt++;
		end
		n = held_cnt;
		if (n >= k)
			rev = 1'b1;
		else if (fin)
			rev = 1'b0;
		else
			return;
		for (int unsigned i = 0; i < n; i++) begin
			w.val       = held_words[rev ? (n - 1 - i) : i];
			w.run_last  = (i == n - 1);
			w.strm_last = fin && (i == n - 1);
			pending_out.push_back(w);
		end
		held_cnt = 0;
	endtask

	// Send one word. Called at a rising edge; returns at the edge that
	// accepted it. Gaps fall between bursts of random length.
	task automatic send_word(input logic signed [VAL_W-1:0] v, input logic fin);
		bit rdy;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			// now and then a long stretch with no gaps at all
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
			                                         : $urandom_range(1, 12);
		end
		burst_left--;
		in_valid   <= 1'b1;
		value      <= v;
		final_item <= fin;
		// ready is stable from the falling edge to the next rising edge
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
		sent_cnt++;
		reorder_predict(v, fin);
	endtask

	// Hold the input off until every owed word has come out.
	task automatic wait_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_out.size() != 0);
	endtask

	// Register write, only while the block is idle. Held words cause no
	// output, so the settle wait covers a read run that may still be winding up.
	task automatic set_group_size(input logic [GS_W-1:0] k);
		wait_drain();
		repeat (SETTLE_CYC) @(posedge clk);
		group_size_we <= 1'b1;
		group_size    <= k;
		@(posedge clk);
		group_size_we <= 1'b0;
		gsize_cur = k;
	endtask

	function automatic logic signed [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return -32'sd1;
			3:       return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	// Sizes 0 and 1: every word passes straight through and ends its own run.
	task automatic test_pass_through();
		set_group_size(5'd0);
		send_word(32'sh8000_0000, 1'b0);
		send_word(32'sh7FFF_FFFF, 1'b0);
		send_word(32'sd0, 1'b0);
		send_word(-32'sd1, 1'b0);
		send_word(32'sh5A5A_A5A5, 1'b1);
		set_group_size(5'd1);
		send_word(32'sh0123_4567, 1'b1);
	endtask

	// Two full groups; the final word lands on a full group, so it is reversed.
	task automatic test_full_groups();
		set_group_size(5'd3);
		for (int i = 1; i <= 6; i++)
			send_word(i * 32'sd1000 - 32'sd3000, i == 6);
	endtask

	// Short trailing group leaves in arrival order.
	task automatic test_short_tail();
		set_group_size(5'd4);
		send_word(32'sd11, 1'b0);
		send_word(-32'sd22, 1'b0);
		send_word(32'sd33, 1'b1);
	endtask

	// Oversize register, then lowered below the held count mid-group:
	// held words plus the next one flush reversed as one run.
	task automatic test_size_lowered();
		set_group_size(5'd31);
		send_word(32'sd101, 1'b0);
		send_word(32'sd102, 1'b0);
		send_word(32'sd103, 1'b0);
		set_group_size(5'd2);
		send_word(32'sd104, 1'b0);
	endtask

	// Size dropped to pass-through mid-group: reversed flush, then pass-through.
	task automatic test_size_to_pass();
		set_group_size(5'd5);
		send_word(-32'sd7, 1'b0);
		send_word(-32'sd8, 1'b0);
		set_group_size(5'd1);
		send_word(-32'sd9, 1'b0);
		send_word(-32'sd10, 1'b1);
	endtask

	// Streams under random sizes. Mostly small groups, some full-size and
	// oversize; some phases stop mid-group so the next size change hits
	// held words.
	task automatic test_random_streams();
		logic [GS_W-1:0] k;
		int unsigned     keff;
		int unsigned     len;
		bit              cut;
		while (sent_cnt < RAND_WORDS) begin
			case ($urandom_range(0, 19))
				0:       k = 5'd0;
				1:       k = 5'd1;
				2:       k = 5'($urandom_range(17, 31));
				3:       k = 5'd16;
				4, 5:    k = 5'($urandom_range(7, 15));
				default: k = 5'($urandom_range(2, 6));
			endcase
			set_group_size(k);
			keff = (k > MAX_GROUP) ? MAX_GROUP : ((k < 2) ? 2 : k);
			len  = $urandom_range(1, 3 * keff + 2);
			cut  = ($urandom_range(0, 3) == 0);
			for (int unsigned i = 0; i < len; i++)
				send_word(rand_value(), (i == len - 1) && !cut);
			// pause until the block has emptied its output
			if ($urandom_range(0, 4) == 0)
				wait_drain();
		end
		send_word(rand_value(), 1'b1);
	endtask

	// Receiver: out_ready follows a rotating 8-bit pattern, reloaded each time
	// the 5-bit tick counter wraps; a third of the reloads are all-ones (no stalls).
	logic [7:0] rx_pat = 8'hFF;
	logic [4:0] rx_tick = '0;
	always @(posedge clk) begin
		if (arst_n) begin
			rx_tick <= rx_tick + 1'b1;
			if (rx_tick == '1)
				rx_pat <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
			else
				rx_pat <= {rx_pat[0], rx_pat[7:1]};
			out_ready <= rx_pat[0];
		end
	end

	// Checker: a word sampled at the falling edge is taken at the next rise.
	always @(negedge clk) begin
		out_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_out.size() == 0) begin
				$display("%0t: unexpected word value_res=%0d run_end=%0b stream_end=%0b",
				         $time, value_res, run_end, stream_end);
				err_cnt++;
			end else begin
				w = pending_out.pop_front();
				if (value_res !== w.val) begin
					$display("%0t: value_res expected %0d actual %0d", $time, w.val, value_res);
					err_cnt++;
				end
				if (run_end !== w.run_last) begin
					$display("%0t: run_end expected %0b actual %0b", $time, w.run_last, run_end);
					err_cnt++;
				end
				if (stream_end !== w.strm_last) begin
					$display("%0t: stream_end expected %0b actual %0b",
					         $time, w.strm_last, stream_end);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pass_through();
		test_full_groups();
		test_short_tail();
		test_size_lowered();
		test_size_to_pass();
		test_random_streams();

		wait_drain();
		repeat (2 * SETTLE_CYC) @(posedge clk);
		if (pending_out.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, pending_out.size());
			err_cnt++;
		end
		if (err_cnt == 0) begin
			$display("block_reverse_every_k_core_tb: PASS");
		end else begin
			$display("block_reverse_every_k_core_tb: FAIL");
		end
		$finish;
	end

endmodule
